// ===== sv/ppd_pkg.sv =====
// shared constants, control types and residue helper for the pulldown phase detector
package ppd_pkg;

    localparam int CNT_W     = 8;
    localparam int NUM_RES   = 5;
    localparam int PHASE_W   = 3;
    localparam int PAIR_W    = CNT_W + 1;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = CFG_W + CNT_W;

    // match codes
    localparam logic [1:0] KIND_P = 2'd1;

    // entry with a combing metric at or above this is noise
    localparam logic [CNT_W-1:0] NOISE_MIC = 8'd80;
    localparam logic [CNT_W-1:0] CNT_MAX   = 8'hFF;

    localparam logic [PHASE_W-1:0] PHASE_UNKNOWN = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOM_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_RATIO = 2'd2;

    // configuration reset values
    localparam logic [CNT_W-1:0] MIN_VALID_RST  = 8'd6;
    localparam logic [CFG_W-1:0] DOM_RATIO_RST  = 9'd230;
    localparam logic [CFG_W-1:0] KEEP_RATIO_RST = 9'd205;

    // controller to datapath commands
    typedef struct packed {
        logic count;   // word accepted, update counters
        logic last;    // accepted word closes the window
        logic eval;    // form pair sums and products
        logic decide;  // load result and clear counters
    } ppd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
    } ppd_status_t;

    // frame number mod 5: 16 = 1 mod 5, so nibbles add up to the same residue
    function automatic logic [PHASE_W-1:0] frame_mod5(input logic [31:0] v);
        logic [6:0] nsum;
        logic [4:0] fold;
        logic [4:0] r;
        nsum = '0;
        for (int i = 0; i < 8; i++) begin
            nsum = nsum + {3'b000, v[4*i +: 4]};
        end
        fold = {2'b00, nsum[6:4]} + {1'b0, nsum[3:0]};
        r = fold;
        if (r >= 5'd20) begin
            r = r - 5'd20;
        end else if (r >= 5'd15) begin
            r = r - 5'd15;
        end else if (r >= 5'd10) begin
            r = r - 5'd10;
        end else if (r >= 5'd5) begin
            r = r - 5'd5;
        end
        return r[PHASE_W-1:0];
    endfunction

endpackage

// ===== sv/ppd_ctrl.sv =====
// controller state machine for the pulldown phase detector
module ppd_ctrl
    import ppd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_window_end,
    output logic        s_ready,
    input  ppd_status_t status,
    output ppd_cmd_t    cmd
);

    localparam logic [1:0] S_RUN    = 2'd0;
    localparam logic [1:0] S_PAIR   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // words are taken only while counting
    assign s_ready = (state_reg == S_RUN);

    // command decode
    always_comb begin
        cmd.count  = (state_reg == S_RUN) && s_valid;
        cmd.last   = cmd.count && s_window_end;
        cmd.eval   = (state_reg == S_PAIR);
        cmd.decide = (state_reg == S_DECIDE) && status.out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_RUN: begin
                if (cmd.last) begin
                    state_next = S_PAIR;
                end
            end
            S_PAIR: begin
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (status.out_free) begin
                    state_next = S_RUN;
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    // a closing word always leads into the pair evaluation
    a_last_to_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.last |=> (state_reg == S_PAIR))
        else $error("window end not followed by pair evaluation");

    // evaluation is always followed by the decision step
    a_pair_to_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |=> (state_reg == S_DECIDE))
        else $error("pair evaluation not followed by decision");

    // no word is counted while a decision is pending
    a_no_count_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PAIR || state_reg == S_DECIDE) |-> !cmd.count)
        else $error("word counted during decision");

endmodule

// ===== sv/ppd_datapath.sv =====
// residue counters, configuration, phase decision and output register
module ppd_datapath
    import ppd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ppd_cmd_t             cmd,
    output ppd_status_t          status,
    input  logic [31:0]          s_frame_number,
    input  logic [1:0]           s_match_kind,
    input  logic                 s_combed,
    input  logic [CNT_W-1:0]     s_combing_metric,
    input  logic [PHASE_W-1:0]   s_phase_now,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PHASE_W-1:0]   m_chosen_phase,
    output logic                 m_phase_changed
);

    logic [CNT_W-1:0]   cnt_reg [NUM_RES];
    logic [CNT_W-1:0]   total_reg;
    logic [CNT_W-1:0]   cfg_min_reg;
    logic [CFG_W-1:0]   cfg_dom_reg;
    logic [CFG_W-1:0]   cfg_keep_reg;
    logic [PHASE_W-1:0] cur_reg;
    logic [PHASE_W-1:0] best_idx_reg;
    logic [PHASE_W-1:0] best_idx_next;
    logic [PAIR_W-1:0]  best_sum_reg;
    logic [PAIR_W-1:0]  best_sum_next;
    logic [PAIR_W-1:0]  cur_sum_reg;
    logic [PAIR_W-1:0]  cur_sum_next;
    logic [PROD_W-1:0]  dom_prod_reg;
    logic [PROD_W-1:0]  keep_prod_reg;
    logic               below_min_reg;
    logic               m_valid_reg;
    logic [PHASE_W-1:0] m_chosen_phase_reg;
    logic               m_phase_changed_reg;

    logic               entry_ok;
    logic [PHASE_W-1:0] residue;
    logic [PAIR_W-1:0]  psum [NUM_RES];
    logic               keep_cur;
    logic [PHASE_W-1:0] chosen;

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_chosen_phase  = m_chosen_phase_reg;
    assign m_phase_changed = m_phase_changed_reg;

    // entry qualification and residue of the frame number
    assign entry_ok = (s_match_kind == KIND_P) && (s_combing_metric < NOISE_MIC) && !s_combed;
    assign residue  = frame_mod5(s_frame_number);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_min_reg  <= MIN_VALID_RST;
            cfg_dom_reg  <= DOM_RATIO_RST;
            cfg_keep_reg <= KEEP_RATIO_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_VALID:  cfg_min_reg  <= cfg_wr_data[CNT_W-1:0];
                CFG_DOM_RATIO:  cfg_dom_reg  <= cfg_wr_data;
                CFG_KEEP_RATIO: cfg_keep_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // saturating residue counters, cleared after each decision
    for (genvar g = 0; g < NUM_RES; g++) begin : g_cnt
        always_ff @(posedge aclk) begin
            if (!aresetn || cmd.decide) begin
                cnt_reg[g] <= '0;
            end else if (cmd.count && entry_ok && residue == PHASE_W'(g)
                         && cnt_reg[g] != CNT_MAX) begin
                cnt_reg[g] <= cnt_reg[g] + 1'b1;
            end
        end
    end

    // saturating valid total
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.decide) begin
            total_reg <= '0;
        end else if (cmd.count && entry_ok && total_reg != CNT_MAX) begin
            total_reg <= total_reg + 1'b1;
        end
    end

    // phase in force, out of range codes count as unknown
    always_ff @(posedge aclk) begin
        if (cmd.last) begin
            cur_reg <= (s_phase_now > PHASE_UNKNOWN) ? PHASE_UNKNOWN : s_phase_now;
        end
    end

    // adjacent pair sums, best pair search and current pair pick
    always_comb begin
        for (int i = 0; i < NUM_RES; i++) begin
            psum[i] = {1'b0, cnt_reg[i]} + {1'b0, cnt_reg[(i + 1) % NUM_RES]};
        end
        best_idx_next = '0;
        best_sum_next = psum[0];
        for (int i = 1; i < NUM_RES; i++) begin
            if (psum[i] > best_sum_next) begin
                best_sum_next = psum[i];
                best_idx_next = PHASE_W'(i);
            end
        end
        cur_sum_next = '0;
        for (int i = 0; i < NUM_RES; i++) begin
            if (cur_reg == PHASE_W'(i)) begin
                cur_sum_next = psum[i];
            end
        end
    end

    // evaluation stage: pair results and ratio products
    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            best_idx_reg  <= best_idx_next;
            best_sum_reg  <= best_sum_next;
            cur_sum_reg   <= cur_sum_next;
            below_min_reg <= total_reg < cfg_min_reg;
            dom_prod_reg  <= {{CNT_W{1'b0}}, cfg_dom_reg} * {{CFG_W{1'b0}}, total_reg};
            keep_prod_reg <= {{CNT_W{1'b0}}, cfg_keep_reg} * {{CFG_W{1'b0}}, total_reg};
        end
    end

    // keep or switch decision
    always_comb begin
        keep_cur = below_min_reg
                || ({best_sum_reg, 8'h00} < dom_prod_reg)
                || ((cur_reg != PHASE_UNKNOWN) && ({cur_sum_reg, 8'h00} >= keep_prod_reg));
        chosen   = keep_cur ? cur_reg : best_idx_reg;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.decide) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            m_chosen_phase_reg  <= chosen;
            m_phase_changed_reg <= (chosen != cur_reg);
        end
    end

    // no residue counter can run ahead of the valid total
    a_total_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg >= cnt_reg[0] && total_reg >= cnt_reg[1] && total_reg >= cnt_reg[2]
        && total_reg >= cnt_reg[3] && total_reg >= cnt_reg[4])
        else $error("residue counter exceeds valid total");

    // counters start empty after a decision
    a_clear_after_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |=> (total_reg == '0))
        else $error("valid total not cleared after decision");

    // a decision never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.decide |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");

    // a delivered phase is a known phase or unknown
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_chosen_phase_reg <= PHASE_UNKNOWN))
        else $error("chosen phase out of range");

endmodule

// ===== sv/pulldown_phase_detector.sv =====
// 3:2 pulldown cadence phase detector, top level
// throughput: one word per cycle inside a window; after the closing word s_ready stays low
//   while pair sums and ratio products are formed (S_PAIR) and compared (S_DECIDE),
//   and for as long as an earlier result still waits on m_ready
// result path: pair results are registered in S_PAIR, then loaded into the output register in S_DECIDE
// reset: synchronous active-low aresetn clears counters and output, loads default ratios
module pulldown_phase_detector
    import ppd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_frame_number,
    input  logic [1:0]           s_match_kind,
    input  logic                 s_combed,
    input  logic [CNT_W-1:0]     s_combing_metric,
    input  logic [PHASE_W-1:0]   s_phase_now,
    input  logic                 s_window_end,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [PHASE_W-1:0]   m_chosen_phase,
    output logic                 m_phase_changed,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    ppd_cmd_t    cmd;
    ppd_status_t status;

    // sequencing
    ppd_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_window_end (s_window_end),
        .s_ready      (s_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // counting and decision
    ppd_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_frame_number   (s_frame_number),
        .s_match_kind     (s_match_kind),
        .s_combed         (s_combed),
        .s_combing_metric (s_combing_metric),
        .s_phase_now      (s_phase_now),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_chosen_phase   (m_chosen_phase),
        .m_phase_changed  (m_phase_changed)
    );

endmodule

// ===== test/tb_top.sv =====
// testbench for the pulldown phase detector: directed and random field-match windows
// checked word by word against a behavioral cadence predictor
module tb_top;
    import ppd_pkg::*;

    localparam logic [1:0] MATCH_C     = 2'd0;
    localparam logic [1:0] MATCH_H     = 2'd2;
    localparam logic [1:0] MATCH_SPARE = 2'd3;
    localparam logic [PHASE_W-1:0] PHASE_RAW_MAX = 3'd7;
    localparam int CADENCE        = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1150;

    typedef struct packed {
        logic [31:0]        frame_number;
        logic [1:0]         match_kind;
        logic               combed;
        logic [CNT_W-1:0]   combing_metric;
        logic [PHASE_W-1:0] phase_now;
        logic               window_end;
    } entry_t;

    typedef struct packed {
        logic [PHASE_W-1:0] chosen_phase;
        logic               phase_changed;
    } phase_result_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [31:0]          s_frame_number;
    logic [1:0]           s_match_kind;
    logic                 s_combed;
    logic [CNT_W-1:0]     s_combing_metric;
    logic [PHASE_W-1:0]   s_phase_now;
    logic                 s_window_end;
    logic                 m_valid;
    logic                 m_ready;
    logic [PHASE_W-1:0]   m_chosen_phase;
    logic                 m_phase_changed;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;

    pulldown_phase_detector i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_frame_number   (s_frame_number),
        .s_match_kind     (s_match_kind),
        .s_combed         (s_combed),
        .s_combing_metric (s_combing_metric),
        .s_phase_now      (s_phase_now),
        .s_window_end     (s_window_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_chosen_phase   (m_chosen_phase),
        .m_phase_changed  (m_phase_changed),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    // pending entries for the driver, predicted phases for the monitor
    entry_t        entry_q[$];
    phase_result_t phase_q[$];

    // predictor state and its copy of the registers
    logic [CNT_W-1:0] residue_hits [CADENCE];
    logic [CNT_W-1:0] valid_hits;
    logic [CNT_W-1:0] min_valid_cfg;
    logic [CFG_W-1:0] dom_ratio_cfg;
    logic [CFG_W-1:0] keep_ratio_cfg;

    int            mismatches;
    int            idle_cycles;
    int            burst_left;
    int            gap_left;
    rx_mode_t      rx_mode;
    int            rx_left;
    int            random_items;
    phase_result_t want_result;

    // clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void note_mismatch(input string what, input int want, input int got);
        if (mismatches < 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
        mismatches++;
    endfunction

    // count one accepted entry; on the closing entry work out the phase decision
    task automatic count_and_decide(input entry_t e);
        int pair_sum [CADENCE];
        int best_sum;
        int total;
        int i;
        logic [2:0] res;
        logic [PHASE_W-1:0] cur;
        logic [PHASE_W-1:0] best;
        logic [PHASE_W-1:0] pick;
        phase_result_t r;
        if (e.match_kind == KIND_P && e.combing_metric < NOISE_MIC && !e.combed) begin
            res = 3'(e.frame_number % 32'd5);
            if (residue_hits[res] != CNT_MAX) begin
                residue_hits[res] = residue_hits[res] + 1'b1;
            end
            if (valid_hits != CNT_MAX) begin
                valid_hits = valid_hits + 1'b1;
            end
        end
        if (e.window_end) begin
            cur = (e.phase_now > PHASE_UNKNOWN) ? PHASE_UNKNOWN : e.phase_now;
            total = int'(valid_hits);
            for (i = 0; i < CADENCE; i++) begin
                pair_sum[i] = int'(residue_hits[i]) + int'(residue_hits[(i + 1) % CADENCE]);
            end
            // strongest pair, lowest start wins a tie
            best = '0;
            best_sum = pair_sum[0];
            for (i = 1; i < CADENCE; i++) begin
                if (pair_sum[i] > best_sum) begin
                    best_sum = pair_sum[i];
                    best = 3'(i);
                end
            end
            // ratio tests in q1.8, cross-multiplied
            if (total < int'(min_valid_cfg)) begin
                pick = cur;
            end else if (best_sum * 256 < int'(dom_ratio_cfg) * total) begin
                pick = cur;
            end else if (cur != PHASE_UNKNOWN &&
                         pair_sum[cur] * 256 >= int'(keep_ratio_cfg) * total) begin
                pick = cur;
            end else begin
                pick = best;
            end
            r.chosen_phase = pick;
            r.phase_changed = (pick != cur);
            phase_q = {phase_q, r};
            for (i = 0; i < CADENCE; i++) begin
                residue_hits[i] = '0;
            end
            valid_hits = '0;
        end
    endtask

    task automatic push_entry(input logic [31:0] frame, input logic [1:0] kind,
                              input logic combed, input logic [CNT_W-1:0] mic,
                              input logic [PHASE_W-1:0] phase, input logic last);
        entry_t e;
        e.frame_number = frame;
        e.match_kind = kind;
        e.combed = combed;
        e.combing_metric = mic;
        e.phase_now = phase;
        e.window_end = last;
        entry_q = {entry_q, e};
    endtask

    // window that follows a 3:2 cadence locked to a random pair, with tunable noise
    task automatic push_cadence_window(input int len, input int noise_pct);
        logic [31:0] base;
        logic [31:0] frame;
        logic [1:0] kind;
        logic [CNT_W-1:0] mic;
        logic [PHASE_W-1:0] phase;
        int lock;
        int res;
        int k;
        base = $urandom();
        lock = $urandom_range(0, CADENCE - 1);
        for (k = 0; k < len; k++) begin
            frame = base + k;
            // an occasional frame out of sequence
            if ($urandom_range(0, 99) < 3) begin
                frame = $urandom();
            end
            res = int'(frame % 32'd5);
            if ($urandom_range(0, 99) < noise_pct) begin
                kind = 2'($urandom_range(0, 3));
            end else if (res == lock || res == (lock + 1) % CADENCE) begin
                kind = KIND_P;
            end else begin
                kind = ($urandom_range(0, 7) == 0) ? MATCH_H : MATCH_C;
            end
            if ($urandom_range(0, 99) < noise_pct) begin
                mic = CNT_W'($urandom_range(int'(NOISE_MIC), 255));
            end else begin
                mic = CNT_W'($urandom_range(0, int'(NOISE_MIC) - 1));
            end
            phase = PHASE_W'($urandom_range(0, 7));
            if (k == len - 1 && $urandom_range(0, 1) == 1) begin
                phase = PHASE_W'(lock);
            end
            push_entry(frame, kind, $urandom_range(0, 99) < noise_pct / 2, mic, phase,
                       k == len - 1);
        end
    endtask

    // window of unrelated entries
    task automatic push_noise_window(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            push_entry($urandom(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       CNT_W'($urandom_range(0, 255)), PHASE_W'($urandom_range(0, 7)),
                       k == len - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_MIN_VALID: min_valid_cfg = value[CNT_W-1:0];
            CFG_DOM_RATIO: dom_ratio_cfg = value;
            default: keep_ratio_cfg = value;
        endcase
    endtask

    task automatic set_config(input logic [CNT_W-1:0] min_v, input logic [CFG_W-1:0] dom_v,
                              input logic [CFG_W-1:0] keep_v);
        write_reg(CFG_MIN_VALID, {1'($urandom_range(0, 1)), min_v});
        write_reg(CFG_DOM_RATIO, dom_v);
        write_reg(CFG_KEEP_RATIO, keep_v);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_ratio();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return CFG_W'(256);
            2: return '1;
            3: return CFG_W'($urandom_range(0, 511));
            default: return CFG_W'($urandom_range(128, 256));
        endcase
    endfunction

    // let every word drain, then give the closing pipeline time to settle
    task automatic wait_idle();
        while (entry_q.size() != 0 || s_valid || phase_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                count_and_decide({s_frame_number, s_match_kind, s_combed, s_combing_metric,
                                  s_phase_now, s_window_end});
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (entry_q.size() != 0) begin
                    {s_frame_number, s_match_kind, s_combed, s_combing_metric,
                     s_phase_now, s_window_end} <= entry_q.pop_front();
                    s_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern that switches to a random style whenever its run counter expires
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_mode = RX_OPEN;
            rx_left = 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 80);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN: m_ready <= 1'b1;
                RX_COIN: m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_left % 4 == 0);
                default: m_ready <= (rx_left % 7 > 2);
            endcase
        end
    end

    // result check against the oldest predicted phase
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (phase_q.size() == 0) begin
                note_mismatch("unexpected word, chosen_phase", -1, int'(m_chosen_phase));
            end else begin
                want_result = phase_q.pop_front();
                if (m_chosen_phase !== want_result.chosen_phase) begin
                    note_mismatch("chosen_phase", int'(want_result.chosen_phase),
                                  int'(m_chosen_phase));
                end
                if (m_phase_changed !== want_result.phase_changed) begin
                    note_mismatch("phase_changed", int'(want_result.phase_changed),
                                  int'(m_phase_changed));
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        int k;
        int len;
        logic [CNT_W-1:0] min_v;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_frame_number = '0;
        s_match_kind = MATCH_C;
        s_combed = 1'b0;
        s_combing_metric = '0;
        s_phase_now = '0;
        s_window_end = 1'b0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_MIN_VALID;
        cfg_wr_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        random_items = 0;
        for (k = 0; k < CADENCE; k++) begin
            residue_hits[k] = '0;
        end
        valid_hits = '0;
        min_valid_cfg = MIN_VALID_RST;
        dom_ratio_cfg = DOM_RATIO_RST;
        keep_ratio_cfg = KEEP_RATIO_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // default ratios: every kind of noise next to valid p words, frame extremes,
        // out-of-range phase on the closing word
        push_entry(32'd0, KIND_P, 1'b0, 8'd0, 3'd0, 1'b0);
        push_entry(32'd1, KIND_P, 1'b0, NOISE_MIC - 1'b1, 3'd0, 1'b0);
        push_entry(32'hFFFF_FFFF, KIND_P, 1'b0, 8'd0, 3'd4, 1'b0);
        push_entry(32'd6, KIND_P, 1'b0, NOISE_MIC, 3'd0, 1'b0);
        push_entry(32'd6, MATCH_H, 1'b0, 8'd0, 3'd0, 1'b0);
        push_entry(32'd6, MATCH_C, 1'b0, 8'd0, 3'd0, 1'b0);
        push_entry(32'd6, MATCH_SPARE, 1'b0, 8'd0, 3'd0, 1'b0);
        push_entry(32'd6, KIND_P, 1'b1, 8'd0, 3'd0, 1'b0);
        push_entry(32'd6, KIND_P, 1'b0, 8'hFF, 3'd0, 1'b0);
        push_entry(32'd6, KIND_P, 1'b0, 8'd0, 3'd0, 1'b0);
        push_entry(32'd5, KIND_P, 1'b0, 8'd0, 3'd0, 1'b0);
        push_entry(32'd11, KIND_P, 1'b0, 8'd0, PHASE_RAW_MAX, 1'b1);
        // too few valid words: current phase stays
        push_entry(32'd0, KIND_P, 1'b1, 8'd0, 3'd3, 1'b1);
        // strong pair matching the current phase, then the same pair against phase 0
        for (k = 0; k < 12; k++) begin
            push_entry(32'(2 + 5 * (k % 6 / 2) + k % 2), KIND_P, 1'b0, 8'd0,
                       (k < 6) ? 3'd2 : 3'd0, k == 5 || k == 11);
        end
        wait_idle();

        // zero minimum with empty windows
        set_config('0, CFG_W'(256), '0);
        push_entry(32'd3, MATCH_C, 1'b0, 8'd0, PHASE_UNKNOWN, 1'b1);
        push_entry(32'd3, MATCH_H, 1'b0, 8'd0, 3'd2, 1'b1);
        push_cadence_window(20, 10);
        wait_idle();

        // counter saturation on one residue
        set_config(CNT_MAX, CFG_W'(256), '1);
        for (k = 0; k < 280; k++) begin
            push_entry(32'(5 * k + 3), KIND_P, 1'b0, 8'(k % 80), 3'd3, k == 279);
        end
        wait_idle();

        // random phases, each with its own register setting
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0: min_v = '0;
                1: min_v = 8'd1;
                2: min_v = CNT_MAX;
                default: min_v = CNT_W'($urandom_range(1, 16));
            endcase
            set_config(min_v, pick_ratio(), pick_ratio());
            repeat ($urandom_range(3, 8)) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(31, 128)
                                                  : $urandom_range(1, 30);
                if ($urandom_range(0, 4) == 0) begin
                    push_noise_window(len);
                end else begin
                    case ($urandom_range(0, 3))
                        0: push_cadence_window(len, 0);
                        1: push_cadence_window(len, 10);
                        2: push_cadence_window(len, 30);
                        default: push_cadence_window(len, 60);
                    endcase
                end
                random_items += len;
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
